[sv/lsi_pkg.sv]
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared constants, item types and helper functions of the luma sub-sample
// interpolator.
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int MAX_BLOCK_WIDTH  = 64;
  localparam int MAX_BLOCK_HEIGHT = 64;
  localparam int TAPS             = 8;
  localparam int PIXEL_BITS       = 8;
  localparam int STORE_ROWS       = TAPS - 1;

  localparam int COEF_W     = 8;
  localparam int HSUM_W     = 16;
  localparam int SIZE_W     = 7;
  localparam int FRAC_W     = 2;
  localparam int CFG_DATA_W = TAPS * COEF_W;
  localparam int CFG_IDX_W  = 3;

  localparam int XW     = $clog2(MAX_BLOCK_WIDTH);
  localparam int CW     = $clog2(MAX_BLOCK_WIDTH + TAPS);
  localparam int RW     = $clog2(MAX_BLOCK_HEIGHT + TAPS);
  localparam int SLOT_W = $clog2(STORE_ROWS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QW          = $clog2(QUEUE_DEPTH);

  localparam int HPROD_W = COEF_W + PIXEL_BITS + 1;
  localparam int HACC_W  = HPROD_W + $clog2(TAPS);
  localparam int VPROD_W = COEF_W + HSUM_W;
  localparam int VACC_W  = VPROD_W + $clog2(TAPS);

  localparam int ROUND_OFS = 2048;
  localparam int OUT_SHIFT = 12;
  localparam int PIX_MAX   = 2 ** PIXEL_BITS - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_PHASE0,
    CFG_COEF_PHASE1,
    CFG_COEF_PHASE2,
    CFG_COEF_PHASE3,
    CFG_HOR_FRAC,
    CFG_VER_FRAC,
    CFG_BLOCK_WIDTH,
    CFG_BLOCK_HEIGHT
  } cfg_idx_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] src_pixel;
    logic                  block_start;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pred_pixel;
    logic                  row_end;
    logic                  block_end;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic row_end;
    logic block_end;
  } tag_t;

  // one horizontal filter job: window, line-store column and row slot
  typedef struct packed {
    logic [TAPS-1:0][PIXEL_BITS-1:0] window;
    logic [XW-1:0]                   x;
    logic [SLOT_W-1:0]               slot;
    tag_t                            tag;
  } cmd_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W:0]   limit);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if ({1'b0, v} > limit) begin
      r = limit[SIZE_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] tap_of(input logic [CFG_DATA_W-1:0] set,
                                                      input int i);
    return set[COEF_W*i +: COEF_W];
  endfunction

endpackage

[sv/lsi_front.sv]
// ----------------------------------------------------------------------------
// lsi_front
// Takes pixel items, tracks column, row and line-store slot, keeps the row
// window and queues one filter job for every pixel that feeds the store.
// ----------------------------------------------------------------------------
module lsi_front import lsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  input  logic [SIZE_W-1:0] eff_w,
  input  logic [SIZE_W-1:0] eff_h,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [TAPS-1:0][PIXEL_BITS-1:0] win_r, win_nxt, win_sh;
  logic [CW-1:0]     col_r, col_nxt, col_cur, xw;
  logic [RW-1:0]     row_r, row_nxt, row_cur, yw;
  logic [SLOT_W-1:0] slot_r, slot_nxt, slot_cur;
  logic              acc, store, emit, rend, bend, col_last, row_last;

  always_comb begin
    acc      = in_valid && !q_full;
    in_stall = q_full;

    col_cur  = in_data.block_start ? '0 : col_r;
    row_cur  = in_data.block_start ? '0 : row_r;
    slot_cur = in_data.block_start ? '0 : slot_r;

    for (int i = 0; i < TAPS - 1; i++) begin
      win_sh[i] = win_r[i+1];
    end
    win_sh[TAPS-1] = in_data.src_pixel;

    xw    = col_cur - CW'(STORE_ROWS);
    yw    = row_cur - RW'(STORE_ROWS);
    store = (col_cur >= CW'(STORE_ROWS)) && (xw < CW'(MAX_BLOCK_WIDTH));
    emit  = store && (row_cur >= RW'(STORE_ROWS));
    rend  = ({1'b0, xw} + (CW+1)'(1)) >= (CW+1)'(eff_w);
    bend  = rend && (({1'b0, yw} + (RW+1)'(1)) >= (RW+1)'(eff_h));

    col_last = ({1'b0, col_cur} + (CW+1)'(1)) >= ((CW+1)'(eff_w) + (CW+1)'(STORE_ROWS));
    row_last = ({1'b0, row_cur} + (RW+1)'(1)) >= ((RW+1)'(eff_h) + (RW+1)'(STORE_ROWS));

    win_nxt  = win_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (acc) begin
      win_nxt = win_sh;
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_cur + RW'(1);
          slot_nxt = (slot_cur == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_cur + SLOT_W'(1);
        end
      end else begin
        col_nxt  = col_cur + CW'(1);
        row_nxt  = row_cur;
        slot_nxt = slot_cur;
      end
    end

    q_push               = acc && store;
    q_cmd.window         = win_sh;
    q_cmd.x              = xw[XW-1:0];
    q_cmd.slot           = slot_cur;
    q_cmd.tag.emit       = emit;
    q_cmd.tag.row_end    = rend;
    q_cmd.tag.block_end  = bend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else begin
      win_r  <= win_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

[sv/lsi_fifo.sv]
// ----------------------------------------------------------------------------
// lsi_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module lsi_fifo import lsi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic not_empty,
  output logic full
);

  cmd_t          entries_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QW:0]   cnt_r, cnt_nxt;

  always_comb begin
    not_empty = (cnt_r != '0);
    full      = (cnt_r == (QW+1)'(QUEUE_DEPTH));
    head_cmd  = entries_r[rd_ptr_r];
    cnt_nxt   = cnt_r + (QW+1)'(push) - (QW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/lsi_back.sv]
// ----------------------------------------------------------------------------
// lsi_back
// Filter pipeline: horizontal taps, line-store update and read, vertical
// taps, rounding and clipping into the output register.
// ----------------------------------------------------------------------------
module lsi_back import lsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  input  logic [CFG_DATA_W-1:0] hset,
  input  logic [CFG_DATA_W-1:0] vset,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  logic en, mem_en;

  // horizontal product stage
  logic                      p_vld_r;
  logic [XW-1:0]             p_x_r;
  logic [SLOT_W-1:0]         p_slot_r;
  tag_t                      p_tag_r;
  logic signed [HPROD_W-1:0] hprod   [TAPS];
  logic signed [HPROD_W-1:0] p_prod_r [TAPS];

  // store stage
  logic signed [HACC_W-1:0]  hacc;
  logic [HSUM_W-1:0]         hsum;
  logic [HSUM_W-1:0]         lstore [STORE_ROWS][MAX_BLOCK_WIDTH];
  logic [HSUM_W-1:0]         rd_r   [STORE_ROWS];
  logic                      h_vld_r;
  logic [SLOT_W-1:0]         h_slot_r;
  tag_t                      h_tag_r;
  logic signed [HSUM_W-1:0]  h_hsum_r;

  // vertical product stage
  logic [SLOT_W:0]           bsel   [STORE_ROWS];
  logic signed [VPROD_W-1:0] vprod  [TAPS];
  logic signed [VPROD_W-1:0] v_prod_r [TAPS];
  logic                      v_vld_r;
  tag_t                      v_tag_r;

  // output stage
  logic signed [VACC_W-1:0]           vacc, rnd;
  logic signed [VACC_W-OUT_SHIFT-1:0] shifted;
  logic [PIXEL_BITS-1:0]              pix;
  logic                               out_valid_r;
  out_item_t                          out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && q_vld;
  assign mem_en    = en && p_vld_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      hprod[i] = tap_of(hset, i) * $signed({1'b0, q_cmd.window[i]});
    end
  end

  always_comb begin
    hacc = '0;
    for (int i = 0; i < TAPS; i++) begin
      hacc = hacc + HACC_W'(p_prod_r[i]);
    end
    hsum = hacc[HSUM_W-1:0];
  end

  // tap i reads the slot of the row i rows after the oldest one
  always_comb begin
    for (int i = 0; i < STORE_ROWS; i++) begin
      bsel[i] = {1'b0, h_slot_r} + (SLOT_W+1)'(i);
      if (bsel[i] >= (SLOT_W+1)'(STORE_ROWS)) begin
        bsel[i] = bsel[i] - (SLOT_W+1)'(STORE_ROWS);
      end
    end
    for (int i = 0; i < STORE_ROWS; i++) begin
      vprod[i] = tap_of(vset, i) * $signed(rd_r[bsel[i][SLOT_W-1:0]]);
    end
    vprod[TAPS-1] = tap_of(vset, TAPS - 1) * h_hsum_r;
  end

  always_comb begin
    vacc = '0;
    for (int i = 0; i < TAPS; i++) begin
      vacc = vacc + VACC_W'(v_prod_r[i]);
    end
    rnd     = vacc + VACC_W'(ROUND_OFS);
    shifted = $signed(rnd[VACC_W-1:OUT_SHIFT]);
    if (shifted < 0) begin
      pix = '0;
    end else if (shifted > (VACC_W-OUT_SHIFT)'(PIX_MAX)) begin
      pix = PIXEL_BITS'(PIX_MAX);
    end else begin
      pix = shifted[PIXEL_BITS-1:0];
    end
  end

  // one bank per stored row: read at x and write of the own slot in the same cycle
  for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (mem_en) begin
        if (p_slot_r == SLOT_W'(b)) begin
          lstore[b][p_x_r] <= hsum;
        end
        rd_r[b] <= lstore[b][p_x_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      h_vld_r     <= 1'b0;
      v_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_vld_r     <= q_vld;
      h_vld_r     <= p_vld_r;
      v_vld_r     <= h_vld_r;
      out_valid_r <= v_vld_r && v_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x_r    <= q_cmd.x;
      p_slot_r <= q_cmd.slot;
      p_tag_r  <= q_cmd.tag;
      p_prod_r <= hprod;
      h_slot_r <= p_slot_r;
      h_tag_r  <= p_tag_r;
      h_hsum_r <= $signed(hsum);
      v_tag_r  <= h_tag_r;
      v_prod_r <= vprod;
      out_data_r.pred_pixel <= pix;
      out_data_r.row_end    <= v_tag_r.row_end;
      out_data_r.block_end  <= v_tag_r.block_end;
    end
  end

endmodule

[sv/luma_subpel_interpolator_core.sv]
// ----------------------------------------------------------------------------
// luma_subpel_interpolator_core
// Separable 8-tap luma sub-sample interpolator for 8-bit pixels.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item_t (src_pixel, block_start)
//   out_     output     out_valid/out_stall out_item_t (pred_pixel, row_end,
//                                                      block_end)
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One pixel item is taken per cycle while the job queue is not full; each job
// passes the product, line-store, vertical product and output stages.
// The line store is seven single-port-write banks read at the same column.
// A stalled output freezes the back pipeline; the four-entry job queue keeps
// the input going until it fills. Reset clears counters, window, pointers and
// valids and loads the configuration defaults; the line store needs no clearing.
// ----------------------------------------------------------------------------
module luma_subpel_interpolator_core import lsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] coef_phase0_r, coef_phase1_r, coef_phase2_r, coef_phase3_r;
  logic [FRAC_W-1:0]     hor_frac_r, ver_frac_r;
  logic [SIZE_W-1:0]     block_width_r, block_height_r;
  logic [CFG_DATA_W-1:0] hset, vset;
  logic [SIZE_W-1:0]     eff_w, eff_h;

  logic q_push, q_pop, q_full, q_not_empty;
  cmd_t q_in_cmd, q_head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_phase0_r  <= '0;
      coef_phase1_r  <= '0;
      coef_phase2_r  <= '0;
      coef_phase3_r  <= '0;
      hor_frac_r     <= '0;
      ver_frac_r     <= '0;
      block_width_r  <= SIZE_W'(8);
      block_height_r <= SIZE_W'(8);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_PHASE0:  coef_phase0_r  <= cfg_wdata;
        CFG_COEF_PHASE1:  coef_phase1_r  <= cfg_wdata;
        CFG_COEF_PHASE2:  coef_phase2_r  <= cfg_wdata;
        CFG_COEF_PHASE3:  coef_phase3_r  <= cfg_wdata;
        CFG_HOR_FRAC:     hor_frac_r     <= cfg_wdata[FRAC_W-1:0];
        CFG_VER_FRAC:     ver_frac_r     <= cfg_wdata[FRAC_W-1:0];
        CFG_BLOCK_WIDTH:  block_width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_BLOCK_HEIGHT: block_height_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (hor_frac_r)
      2'd0:    hset = coef_phase0_r;
      2'd1:    hset = coef_phase1_r;
      2'd2:    hset = coef_phase2_r;
      default: hset = coef_phase3_r;
    endcase
    case (ver_frac_r)
      2'd0:    vset = coef_phase0_r;
      2'd1:    vset = coef_phase1_r;
      2'd2:    vset = coef_phase2_r;
      default: vset = coef_phase3_r;
    endcase
    eff_w = eff_size(block_width_r,  (SIZE_W+1)'(MAX_BLOCK_WIDTH));
    eff_h = eff_size(block_height_r, (SIZE_W+1)'(MAX_BLOCK_HEIGHT));
  end

  lsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in_cmd)
  );

  lsi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .pop       (q_pop),
    .head_cmd  (q_head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_not_empty),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .hset      (hset),
    .vset      (vset),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
